[hw/rtl/etfi_pkg.sv]
`default_nettype none
package etfi_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANT_SEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_RE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_IM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAILOUT_SQ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd5;

  // Fixed register widths
  localparam int VARIANT_W = 4;
  localparam int BAIL_W    = 32;
  localparam int BAIL_FRAC = 24;
  localparam int MAXIT_W   = 16;

  localparam logic [BAIL_W-1:0]  BAIL_RESET  = 32'h0400_0000;
  localparam logic [MAXIT_W-1:0] MAXIT_RESET = 16'd256;

  // Squaring variant codes
  localparam logic [VARIANT_W-1:0] VAR_STD          = 4'd0;
  localparam logic [VARIANT_W-1:0] VAR_CONJ         = 4'd1;
  localparam logic [VARIANT_W-1:0] VAR_ABS_BOTH     = 4'd2;
  localparam logic [VARIANT_W-1:0] VAR_ABS_IM       = 4'd3;
  localparam logic [VARIANT_W-1:0] VAR_NEG_ABS_RE   = 4'd4;
  localparam logic [VARIANT_W-1:0] VAR_FOLD_STD     = 4'd5;
  localparam logic [VARIANT_W-1:0] VAR_FOLD_CONJ    = 4'd6;
  localparam logic [VARIANT_W-1:0] VAR_FOLD_ABS     = 4'd7;
  localparam logic [VARIANT_W-1:0] VAR_FOLD_ABS_IM  = 4'd8;
  localparam logic [VARIANT_W-1:0] VAR_FOLD_NEG_RE  = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP,
    ST_DONE
  } state_t;

  // How an item finished
  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_NORM,
    FIN_OVF,
    FIN_LIMIT
  } fin_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic adv;
    fin_t fin;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_esc;
    logic at_limit;
    logic ovf;
  } dp_sts_t;

endpackage
`default_nettype wire

[hw/rtl/etfi_ctrl.sv]
`default_nettype none
module etfi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire etfi_pkg::dp_sts_t sts,
  output etfi_pkg::dp_cmd_t      cmd
);
  import etfi_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequence one request: multiply, then combine and check, per iteration
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.fin     = FIN_NONE;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (sts.norm_esc) begin
          cmd.fin   = FIN_NORM;
          state_nxt = ST_DONE;
        end else if (sts.at_limit) begin
          cmd.fin   = FIN_LIMIT;
          state_nxt = ST_DONE;
        end else if (sts.ovf) begin
          cmd.fin   = FIN_OVF;
          state_nxt = ST_DONE;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result until taken
  assign out_valid_nxt = cmd.publish | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

endmodule
`default_nettype wire

[hw/rtl/etfi_dp.sv]
`default_nettype none
module etfi_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int ITER_WIDTH  = 16
) (
  input  wire logic                                  clk,
  input  wire etfi_pkg::dp_cmd_t                     cmd,
  output etfi_pkg::dp_sts_t                          sts,
  input  wire logic signed [COORD_WIDTH-1:0]         point_re,
  input  wire logic signed [COORD_WIDTH-1:0]         point_im,
  input  wire logic [etfi_pkg::VARIANT_W-1:0]        variant,
  input  wire logic                                  julia_mode,
  input  wire logic signed [COORD_WIDTH-1:0]         c_re,
  input  wire logic signed [COORD_WIDTH-1:0]         c_im,
  input  wire logic [2*COORD_WIDTH-1:0]              bail,
  input  wire logic [ITER_WIDTH-1:0]                 limit,
  output logic [ITER_WIDTH-1:0]                      iter_count,
  output logic                                       escaped
);
  import etfi_pkg::*;

  localparam int PW   = 2 * COORD_WIDTH;
  localparam int SW   = PW + 1;
  localparam int FRAC = COORD_WIDTH - 4;

  logic signed [COORD_WIDTH-1:0] zr_r, zi_r, cr_r, ci_r;
  logic signed [PW-1:0]          rr_r, ii_r, ri_r;
  logic signed [PW-1:0]          rr_w, ii_w, ri_w;
  logic [ITER_WIDTH-1:0]         it_r;
  logic                          pend_r;
  logic [ITER_WIDTH-1:0]         res_cnt_r;
  logic                          res_esc_r;
  logic [ITER_WIDTH-1:0]         out_cnt_r;
  logic                          out_esc_r;

  logic signed [PW-1:0]          sq, sq_f, ab;
  logic                          fold;
  logic signed [SW-1:0]          nr_w, ni_w;
  logic [SW-COORD_WIDTH:0]       nr_top, ni_top;
  logic [PW-1:0]                 norm;

  // Squares and cross product of the current z
  assign rr_w = zr_r * zr_r;
  assign ii_w = zi_r * zi_r;
  assign ri_w = zr_r * zi_r;

  // Real term, folded for the abs-real variants
  assign sq   = rr_r - ii_r;
  assign fold = variant inside {[VAR_FOLD_STD:VAR_FOLD_NEG_RE]};
  assign sq_f = (fold && sq[PW-1]) ? -sq : sq;

  // Imaginary term per variant; codes past the list iterate the standard form
  always_comb begin
    case (variant)
      VAR_CONJ, VAR_FOLD_CONJ:          ab = -ri_r;
      VAR_ABS_BOTH, VAR_FOLD_ABS:       ab = ri_r[PW-1] ? -ri_r : ri_r;
      VAR_ABS_IM, VAR_FOLD_ABS_IM:      ab = zi_r[COORD_WIDTH-1] ? -ri_r : ri_r;
      VAR_NEG_ABS_RE, VAR_FOLD_NEG_RE:  ab = zr_r[COORD_WIDTH-1] ? ri_r : -ri_r;
      default:                          ab = ri_r;
    endcase
  end

  // Floor back to coordinate scale and add c
  assign nr_w = SW'(sq_f >>> FRAC) + SW'(cr_r);
  assign ni_w = SW'(ab >>> (FRAC - 1)) + SW'(ci_r);

  // Out of coordinate range counts as escape
  assign nr_top  = nr_w[SW-1:COORD_WIDTH-1];
  assign ni_top  = ni_w[SW-1:COORD_WIDTH-1];
  assign sts.ovf = ((nr_top != '0) && (nr_top != '1)) ||
                   ((ni_top != '0) && (ni_top != '1));

  // Squared magnitude of the z produced by the last iteration
  assign norm         = $unsigned(rr_r) + $unsigned(ii_r);
  assign sts.norm_esc = pend_r && (norm > bail);
  assign sts.at_limit = (it_r == limit);

  // Iteration registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr_r   <= julia_mode ? point_re : '0;
      zi_r   <= julia_mode ? point_im : '0;
      cr_r   <= julia_mode ? c_re : point_re;
      ci_r   <= julia_mode ? c_im : point_im;
      it_r   <= '0;
      pend_r <= 1'b0;
    end else if (cmd.adv) begin
      zr_r   <= nr_w[COORD_WIDTH-1:0];
      zi_r   <= ni_w[COORD_WIDTH-1:0];
      it_r   <= it_r + 1'b1;
      pend_r <= 1'b1;
    end
    if (cmd.mul) begin
      rr_r <= rr_w;
      ii_r <= ii_w;
      ri_r <= ri_w;
    end
  end

  // Capture the outcome, then publish it when the output slot frees
  always_ff @(posedge clk) begin
    case (cmd.fin)
      FIN_NORM: begin
        res_cnt_r <= it_r - 1'b1;
        res_esc_r <= 1'b1;
      end
      FIN_OVF: begin
        res_cnt_r <= it_r;
        res_esc_r <= 1'b1;
      end
      FIN_LIMIT: begin
        res_cnt_r <= it_r;
        res_esc_r <= 1'b0;
      end
      default: ;
    endcase
    if (cmd.publish) begin
      out_cnt_r <= res_cnt_r;
      out_esc_r <= res_esc_r;
    end
  end

  assign iter_count = out_cnt_r;
  assign escaped    = out_esc_r;

endmodule
`default_nettype wire

[hw/rtl/escape_time_fractal_iterator.sv]
`default_nettype none
// Escape-time iterator for Mandelbrot and Julia sets over signed Q4.28 points.
// One point is worked on at a time. After the accept cycle each iteration
// has two steps: one through the three coordinate multipliers
// (re^2, im^2, re*im), one to combine, floor, add c and test the magnitude of
// the previous result. A point that never escapes stops at the default limit
// of 256 iterations. The iteration loop through the multipliers sets the time
// from accept to result. The result register lets the next point be accepted
// while the last result waits to be taken.
module escape_time_fractal_iterator #(
  parameter int  COORD_WIDTH = 32,
  parameter int  ITER_WIDTH  = 16,
  localparam int CFG_WIDTH   = (COORD_WIDTH > 32) ? COORD_WIDTH : 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]       in_point_re,
  input  wire logic signed [COORD_WIDTH-1:0]       in_point_im,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ITER_WIDTH-1:0]                    out_iter_count,
  output logic                                     out_escaped,
  input  wire logic                                cfg_wr_en,
  input  wire logic [etfi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_WIDTH-1:0]                cfg_wdata
);
  import etfi_pkg::*;

  localparam int PW        = 2 * COORD_WIDTH;
  localparam int BAIL_SHIFT = 2 * (COORD_WIDTH - 4) - BAIL_FRAC;

  logic [VARIANT_W-1:0]          variant_r;
  logic                          julia_mode_r;
  logic signed [COORD_WIDTH-1:0] c_re_r, c_im_r;
  logic [BAIL_W-1:0]             bailout_r;
  logic [MAXIT_W-1:0]            max_iter_r;
  logic [PW-1:0]                 bail;
  logic [ITER_WIDTH-1:0]         limit;
  dp_cmd_t                       cmd;
  dp_sts_t                       sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r    <= VAR_STD;
      julia_mode_r <= 1'b0;
      c_re_r       <= '0;
      c_im_r       <= '0;
      bailout_r    <= BAIL_RESET;
      max_iter_r   <= MAXIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VARIANT_SEL: variant_r    <= cfg_wdata[VARIANT_W-1:0];
        REG_JULIA_MODE:  julia_mode_r <= cfg_wdata[0];
        REG_JULIA_C_RE:  c_re_r       <= cfg_wdata[COORD_WIDTH-1:0];
        REG_JULIA_C_IM:  c_im_r       <= cfg_wdata[COORD_WIDTH-1:0];
        REG_BAILOUT_SQ:  bailout_r    <= cfg_wdata[BAIL_W-1:0];
        REG_MAX_ITER:    max_iter_r   <= cfg_wdata[MAXIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Bailout at the squared-magnitude scale, limit at counter width
  assign bail  = PW'(bailout_r) << BAIL_SHIFT;
  assign limit = ITER_WIDTH'(max_iter_r);

  etfi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  etfi_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .ITER_WIDTH  (ITER_WIDTH)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .point_re   (in_point_re),
    .point_im   (in_point_im),
    .variant    (variant_r),
    .julia_mode (julia_mode_r),
    .c_re       (c_re_r),
    .c_im       (c_im_r),
    .bail       (bail),
    .limit      (limit),
    .iter_count (out_iter_count),
    .escaped    (out_escaped)
  );

endmodule
`default_nettype wire
